// ===== src/gng_pkg.sv =====
// Shared types, constants and helpers for the grid neighbor generator.
`timescale 1ns / 1ps

package gng_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;
   localparam int DIR_W   = 3;
   localparam int NUM_DIR = 8;
   localparam int WIN_W   = 9;
   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // configuration register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // offsets per direction: up, right, down, left, up-left, up-right, down-right, down-left
   localparam logic signed [1:0] DIR_DX [NUM_DIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                     -2'sd1, 2'sd1, 2'sd1, -2'sd1};
   localparam logic signed [1:0] DIR_DY [NUM_DIR] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                                     -2'sd1, -2'sd1, 2'sd1, 2'sd1};
   // position of each neighbor in the 3x3 window, row-major from the upper-left corner
   localparam int DIR_WIN [NUM_DIR] = '{1, 5, 7, 3, 0, 2, 8, 6};

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } gng_limits_type;

   typedef struct packed {
      logic               is_query;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               walkable;
   } gng_item_type;

   // clamp a configured size to the storage and to the coordinate range
   function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v,
                                                    input int maxv);
      int lim;
      lim = (maxv < 64) ? maxv : 64;
      if (int'(v) > lim) begin
         return SIZE_W'(lim);
      end
      return v;
   endfunction

endpackage

// ===== src/gng_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gng_front.sv =====
// Front end: accepts request beats, drops writes outside the grid, queues the rest.
`timescale 1ns / 1ps

module gng_front import gng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  gng_limits_type     limits,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic               req_cell_walkable,
   output logic               item_valid,
   output gng_item_type       item,
   input  logic               item_pop
);

   localparam int DEPTH = 2;

   gng_item_type entry_ff [DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         accept;
   logic         in_grid;
   logic         push;
   logic         pop;

   assign req_stall = (count_ff == 2'(DEPTH));
   assign accept    = req_valid && !req_stall;
   assign in_grid   = ({1'b0, req_cell_x} < limits.width) &&
                      ({1'b0, req_cell_y} < limits.height);
   // writes that miss the grid leave no trace
   assign push      = accept && ((req_type == REQ_QUERY) || in_grid);
   assign pop       = item_pop && item_valid;

   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff].is_query <= req_type;
         entry_ff[wr_ptr_ff].x        <= req_cell_x;
         entry_ff[wr_ptr_ff].y        <= req_cell_y;
         entry_ff[wr_ptr_ff].walkable <= req_cell_walkable;
      end
   end

endmodule

// ===== src/gng_back.sv =====
// Back end: row-wide map updates and the 3x3 neighbor scan with serial result beats.
`timescale 1ns / 1ps

module gng_back import gng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  gng_limits_type     limits,
   input  logic               item_valid,
   input  gng_item_type       item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_nbr_x,
   output logic [COORD_W-1:0] rsp_nbr_y,
   output logic [DIR_W-1:0]   rsp_direction,
   output logic               rsp_found,
   output logic               rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_Q_R1,
      ST_Q_R2,
      ST_Q_R3,
      ST_Q_MASK,
      ST_Q_EMIT
   } state_type;

   state_type          state_ff, state_in;
   gng_item_type       item_ff, item_in;
   logic [MAX_HEIGHT-1:0] row_valid_ff, row_valid_in;
   logic               rd_valid_ff;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [NUM_DIR-1:0] mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] nbr_x_ff, nbr_x_in;
   logic [COORD_W-1:0] nbr_y_ff, nbr_y_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic               found_ff, found_in;
   logic               last_ff, last_in;

   logic [ROW_W-1:0]     rd_addr;
   logic [MAX_WIDTH-1:0] rd_data;
   logic [MAX_WIDTH-1:0] eff_row;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_addr;
   logic [MAX_WIDTH-1:0] wr_data;
   logic [2:0]           row_bits;
   logic [COORD_W-1:0]   col;

   logic signed [COORD_W+1:0] nx [NUM_DIR];
   logic signed [COORD_W+1:0] ny [NUM_DIR];
   logic [NUM_DIR-1:0]        open_nbr;
   logic [NUM_DIR-1:0]        mask_calc;
   logic [NUM_DIR-1:0]        low_bit;
   logic [DIR_W-1:0]          sel;
   logic                      out_free;

   gng_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rows never written read as blocked
   assign eff_row = rd_valid_ff ? rd_data : '0;

   // columns x-1, x, x+1 of the row just read; wrapped columns are masked later
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col         = item_ff.x + COORD_W'(c) - COORD_W'(1);
         row_bits[c] = eff_row[COL_W'(col)];
      end
   end

   // neighbor coordinates and which of them are inside and walkable
   always_comb begin
      for (int d = 0; d < NUM_DIR; d++) begin
         nx[d] = $signed({2'b00, item_ff.x}) + (COORD_W+2)'(DIR_DX[d]);
         ny[d] = $signed({2'b00, item_ff.y}) + (COORD_W+2)'(DIR_DY[d]);
         open_nbr[d] = (nx[d] >= 0) && (nx[d] < $signed({1'b0, limits.width})) &&
                       (ny[d] >= 0) && (ny[d] < $signed({1'b0, limits.height})) &&
                       win_ff[DIR_WIN[d]];
      end
      mask_calc[3:0] = open_nbr[3:0];
      // a diagonal needs one of its two orthogonal cells open
      mask_calc[4] = open_nbr[4] && (open_nbr[0] || open_nbr[3]);
      mask_calc[5] = open_nbr[5] && (open_nbr[0] || open_nbr[1]);
      mask_calc[6] = open_nbr[6] && (open_nbr[2] || open_nbr[1]);
      mask_calc[7] = open_nbr[7] && (open_nbr[2] || open_nbr[3]);
   end

   always_comb begin
      low_bit = mask_ff & (~mask_ff + NUM_DIR'(1));
      sel     = '0;
      for (int d = 0; d < NUM_DIR; d++) begin
         if (low_bit[d]) begin
            sel = DIR_W'(d);
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign item_pop = (state_ff == ST_IDLE) && item_valid;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      row_valid_in = row_valid_ff;
      win_in       = win_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      nbr_x_in     = nbr_x_ff;
      nbr_y_in     = nbr_y_ff;
      dir_in       = dir_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      rd_addr      = ROW_W'(item_ff.y);
      wr_en        = 1'b0;
      wr_addr      = ROW_W'(item_ff.y);
      wr_data      = eff_row;
      wr_data[COL_W'(item_ff.x)] = item_ff.walkable;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in = item;
               if (item.is_query == REQ_QUERY) begin
                  rd_addr  = ROW_W'(item.y - COORD_W'(1));
                  state_in = ST_Q_R1;
               end else begin
                  rd_addr  = ROW_W'(item.y);
                  state_in = ST_WR_MOD;
               end
            end
         end
         ST_WR_MOD: begin
            wr_en                 = 1'b1;
            row_valid_in[wr_addr] = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_Q_R1: begin
            win_in[2:0] = row_bits;
            rd_addr     = ROW_W'(item_ff.y);
            state_in    = ST_Q_R2;
         end
         ST_Q_R2: begin
            win_in[5:3] = row_bits;
            rd_addr     = ROW_W'(item_ff.y + COORD_W'(1));
            state_in    = ST_Q_R3;
         end
         ST_Q_R3: begin
            win_in[8:6] = row_bits;
            state_in    = ST_Q_MASK;
         end
         ST_Q_MASK: begin
            mask_in  = mask_calc;
            state_in = ST_Q_EMIT;
         end
         ST_Q_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mask_ff == '0) begin
                  nbr_x_in = '0;
                  nbr_y_in = '0;
                  dir_in   = '0;
                  found_in = 1'b0;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  // hand out the lowest pending direction, drop it from the mask
                  mask_in  = mask_ff & ~low_bit;
                  nbr_x_in = nx[sel][COORD_W-1:0];
                  nbr_y_in = ny[sel][COORD_W-1:0];
                  dir_in   = sel;
                  found_in = 1'b1;
                  last_in  = (mask_in == '0);
                  if (mask_in == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_valid_ff <= row_valid_ff[rd_addr];
      item_ff     <= item_in;
      win_ff      <= win_in;
      mask_ff     <= mask_in;
      nbr_x_ff    <= nbr_x_in;
      nbr_y_ff    <= nbr_y_in;
      dir_ff      <= dir_in;
      found_ff    <= found_in;
      last_ff     <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_nbr_x     = nbr_x_ff;
   assign rsp_nbr_y     = nbr_y_ff;
   assign rsp_direction = dir_ff;
   assign rsp_found     = found_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== src/grid_neighbor_generator_unit.sv =====
// Grid neighbor generator: map writes and neighbor queries over a walkability bitmap.
// A query holds the map sequencer for three row reads from the single-read map RAM, a mask
// step and its n output beats (n from 1 to 8), which follow one per cycle while rsp_stall
// is low. A write holds it for a read, then a write back of the row. Writes outside the
// grid are dropped by the front end and never reach the sequencer.
// Reset clears the grid size to 64 x 64 and marks every map row blocked at once.
`timescale 1ns / 1ps

module grid_neighbor_generator_unit import gng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [SIZE_W-1:0]  csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic               req_cell_walkable,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_nbr_x,
   output logic [COORD_W-1:0] rsp_nbr_y,
   output logic [DIR_W-1:0]   rsp_direction,
   output logic               rsp_found,
   output logic               rsp_last
);

   logic [SIZE_W-1:0] grid_width_ff, grid_width_in;
   logic [SIZE_W-1:0] grid_height_ff, grid_height_in;
   gng_limits_type    limits;
   logic              item_valid;
   gng_item_type      item;
   logic              item_pop;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_write_data;
            CSR_GRID_HEIGHT: grid_height_in = csr_write_data;
            default: begin
               grid_width_in  = grid_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   assign limits.width  = limit_size(grid_width_ff, MAX_WIDTH);
   assign limits.height = limit_size(grid_height_ff, MAX_HEIGHT);

   gng_front u_front (
      .clock             (clock),
      .reset             (reset),
      .limits            (limits),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_walkable (req_cell_walkable),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   gng_back u_back (
      .clock         (clock),
      .reset         (reset),
      .limits        (limits),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_nbr_x     (rsp_nbr_x),
      .rsp_nbr_y     (rsp_nbr_y),
      .rsp_direction (rsp_direction),
      .rsp_found     (rsp_found),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== dv/gng_neighbor_checker.sv =====
// Checker for the grid neighbor generator: tracks the map, predicts neighbor beats, compares.
`timescale 1ns / 1ps

module gng_neighbor_checker import gng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [SIZE_W-1:0]  csr_write_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_type,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   input  logic               req_cell_walkable,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [COORD_W-1:0] rsp_nbr_x,
   input  logic [COORD_W-1:0] rsp_nbr_y,
   input  logic [DIR_W-1:0]   rsp_direction,
   input  logic               rsp_found,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 beats_due
);

   typedef enum logic [DIR_W-1:0] {
      DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT,
      DIR_UP_LEFT, DIR_UP_RIGHT, DIR_DOWN_RIGHT, DIR_DOWN_LEFT
   } heading_type;

   typedef struct {
      logic [COORD_W-1:0] nbr_x;
      logic [COORD_W-1:0] nbr_y;
      logic [DIR_W-1:0]   direction;
      logic               found;
      logic               last;
   } nbr_beat_type;

   localparam int STEP_X [NUM_DIR] = '{0, 1, 0, -1, -1, 1, 1, -1};
   localparam int STEP_Y [NUM_DIR] = '{-1, 0, 1, 0, -1, -1, 1, 1};
   // orthogonal sides that open each diagonal, in diagonal order
   localparam heading_type SIDE_A [4] = '{DIR_UP, DIR_UP, DIR_DOWN, DIR_DOWN};
   localparam heading_type SIDE_B [4] = '{DIR_LEFT, DIR_RIGHT, DIR_RIGHT, DIR_LEFT};

   logic              walk_bits [MAX_HEIGHT][MAX_WIDTH];
   logic [SIZE_W-1:0] cols_cfg;
   logic [SIZE_W-1:0] rows_cfg;
   nbr_beat_type      neighbor_beats_due [$];
   nbr_beat_type      due;
   int                mismatch_count;

   function automatic int used_span(input logic [SIZE_W-1:0] v, input int cap);
      int lim;
      lim = (cap < 64) ? cap : 64;
      return (int'(v) > lim) ? lim : int'(v);
   endfunction

   function automatic bit on_grid(input int x, input int y);
      return x >= 0 && y >= 0 && x < used_span(cols_cfg, MAX_WIDTH)
             && y < used_span(rows_cfg, MAX_HEIGHT);
   endfunction

   function automatic void predict_neighbors(input logic [COORD_W-1:0] qx,
                                             input logic [COORD_W-1:0] qy);
      bit           open_dir [NUM_DIR];
      nbr_beat_type hits [NUM_DIR];
      nbr_beat_type beat;
      int           n;
      int           nx;
      int           ny;
      n = 0;
      for (int d = 0; d < NUM_DIR; d++) begin
         nx = int'(qx) + STEP_X[d];
         ny = int'(qy) + STEP_Y[d];
         open_dir[d] = on_grid(nx, ny) && walk_bits[ny][nx] == 1'b1;
      end
      for (int d = 0; d < NUM_DIR; d++) begin
         // a diagonal needs at least one open side
         if (open_dir[d] && (d < 4 || open_dir[SIDE_A[d-4]] || open_dir[SIDE_B[d-4]])) begin
            hits[n].nbr_x     = COORD_W'(int'(qx) + STEP_X[d]);
            hits[n].nbr_y     = COORD_W'(int'(qy) + STEP_Y[d]);
            hits[n].direction = DIR_W'(d);
            hits[n].found     = 1'b1;
            hits[n].last      = 1'b0;
            n++;
         end
      end
      if (n == 0) begin
         beat.nbr_x     = '0;
         beat.nbr_y     = '0;
         beat.direction = DIR_UP;
         beat.found     = 1'b0;
         beat.last      = 1'b1;
         neighbor_beats_due.push_back(beat);
      end else begin
         hits[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) begin
            neighbor_beats_due.push_back(hits[i]);
         end
      end
   endfunction

   initial begin
      fail_count     = 0;
      beats_due      = 0;
      mismatch_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         foreach (walk_bits[r, c]) walk_bits[r][c] = 1'b0;
         cols_cfg = SIZE_RESET;
         rows_cfg = SIZE_RESET;
         neighbor_beats_due.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_GRID_WIDTH) begin
               cols_cfg = csr_write_data;
            end else begin
               rows_cfg = csr_write_data;
            end
         end
         // compare before predicting so a same-edge request cannot jump the queue
         if (rsp_valid && !rsp_stall) begin
            if (neighbor_beats_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected beat x=%0d y=%0d dir=%0d found=%0b last=%0b",
                           $realtime, rsp_nbr_x, rsp_nbr_y, rsp_direction, rsp_found,
                           rsp_last);
               end
            end else begin
               due = neighbor_beats_due.pop_front();
               if (rsp_nbr_x !== due.nbr_x || rsp_nbr_y !== due.nbr_y
                   || rsp_direction !== due.direction || rsp_found !== due.found
                   || rsp_last !== due.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: beat mismatch exp x=%0d y=%0d dir=%0d found=%0b last=%0b",
                              $realtime, due.nbr_x, due.nbr_y, due.direction, due.found,
                              due.last);
                     $display("%0t:                got x=%0d y=%0d dir=%0d found=%0b last=%0b",
                              $realtime, rsp_nbr_x, rsp_nbr_y, rsp_direction, rsp_found,
                              rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_WRITE) begin
               if (on_grid(int'(req_cell_x), int'(req_cell_y))) begin
                  walk_bits[req_cell_y][req_cell_x] = req_cell_walkable;
               end
            end else begin
               predict_neighbors(req_cell_x, req_cell_y);
            end
         end
      end
      fail_count = mismatch_count;
      beats_due  = neighbor_beats_due.size();
   end

endmodule

// ===== dv/tb_grid_neighbor_generator_unit.sv =====
// Testbench top for the grid neighbor generator: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb_grid_neighbor_generator_unit import gng_pkg::*; ();

   localparam int SETTLE_CYCLES     = 40;
   localparam int HOLDOFF_CYCLES    = 300;
   localparam int STUCK_LIMIT       = 3000;
   localparam int NUM_SEGMENTS      = 9;
   localparam int ITEMS_PER_SEGMENT = 55;
   localparam int SEG_COLS [NUM_SEGMENTS] = '{64, 1, 7, 64, 1, 0, 127, 16, 33};
   localparam int SEG_ROWS [NUM_SEGMENTS] = '{64, 1, 5, 1, 64, 9, 100, 16, 64};

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic               csr_index;
   logic [SIZE_W-1:0]  csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic               req_type;
   logic [COORD_W-1:0] req_cell_x;
   logic [COORD_W-1:0] req_cell_y;
   logic               req_cell_walkable;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [COORD_W-1:0] rsp_nbr_x;
   logic [COORD_W-1:0] rsp_nbr_y;
   logic [DIR_W-1:0]   rsp_direction;
   logic               rsp_found;
   logic               rsp_last;
   int                 fail_count;
   int                 beats_due;
   int                 req_idle_pct;
   int                 rsp_idle_pct;
   logic               holdoff_armed;
   int                 stuck_cycles;

   always #1 clock = ~clock;

   grid_neighbor_generator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_walkable (req_cell_walkable),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nbr_x         (rsp_nbr_x),
      .rsp_nbr_y         (rsp_nbr_y),
      .rsp_direction     (rsp_direction),
      .rsp_found         (rsp_found),
      .rsp_last          (rsp_last)
   );

   gng_neighbor_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_walkable (req_cell_walkable),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nbr_x         (rsp_nbr_x),
      .rsp_nbr_y         (rsp_nbr_y),
      .rsp_direction     (rsp_direction),
      .rsp_found         (rsp_found),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .beats_due         (beats_due)
   );

   // offer one beat, entered and left at a falling edge
   task automatic offer_cell(input logic kind, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic walk);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_cell_x        <= x;
      req_cell_y        <= y;
      req_cell_walkable <= walk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drain, let queued map writes retire, then resize the grid
   task automatic set_grid(input int cols, input int rows);
      req_valid <= 1'b0;
      while (beats_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_GRID_WIDTH;
      csr_write_data   <= SIZE_W'(cols);
      @(negedge clock);
      csr_index        <= CSR_GRID_HEIGHT;
      csr_write_data   <= SIZE_W'(rows);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly near the focus cell, sometimes on the grid border or anywhere
   function automatic logic [COORD_W-1:0] pick_axis(input int focus, input int span);
      int r;
      int v;
      r = $urandom_range(9);
      if (r < 6) begin
         v = focus + int'($urandom_range(4)) - 2;
      end else if (r < 8) begin
         case ($urandom_range(3))
            0: v = 0;
            1: v = span - 1;
            2: v = span;
            default: v = 63;
         endcase
      end else begin
         v = $urandom_range(63);
      end
      return COORD_W'(v);
   endfunction

   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_armed && !hold_done) begin
            hold_left = HOLDOFF_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int cols_used;
      int rows_used;
      int focus_x;
      int focus_y;
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_GRID_WIDTH;
      csr_write_data    = '0;
      req_valid         = 1'b0;
      req_type          = REQ_WRITE;
      req_cell_x        = '0;
      req_cell_y        = '0;
      req_cell_walkable = 1'b0;
      req_idle_pct      = 38;
      rsp_idle_pct      = 52;
      holdoff_armed     = 1'b0;
      stuck_cycles      = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner cell, query with the walkable bit set
      offer_cell(REQ_WRITE, 1, 0, 1'b1);
      offer_cell(REQ_WRITE, 0, 1, 1'b1);
      offer_cell(REQ_WRITE, 1, 1, 1'b1);
      offer_cell(REQ_QUERY, 0, 0, 1'b1);
      // far corner: up and up-left
      offer_cell(REQ_WRITE, 63, 62, 1'b1);
      offer_cell(REQ_WRITE, 62, 62, 1'b1);
      offer_cell(REQ_QUERY, 63, 63, 1'b0);
      // diagonal cut off by two blocked sides, then opened by one
      offer_cell(REQ_WRITE, 4, 4, 1'b1);
      offer_cell(REQ_QUERY, 5, 5, 1'b0);
      offer_cell(REQ_WRITE, 5, 4, 1'b1);
      offer_cell(REQ_QUERY, 5, 5, 1'b0);
      // full ring of eight, then block one side
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            if (dx != 0 || dy != 0) begin
               offer_cell(REQ_WRITE, COORD_W'(10 + dx), COORD_W'(10 + dy), 1'b1);
            end
         end
      end
      offer_cell(REQ_QUERY, 10, 10, 1'b0);
      offer_cell(REQ_WRITE, 10, 9, 1'b0);
      offer_cell(REQ_QUERY, 10, 10, 1'b0);
      // small grid: writes and queries off the grid, then an empty grid
      set_grid(3, 2);
      offer_cell(REQ_WRITE, 3, 0, 1'b1);
      offer_cell(REQ_WRITE, 2, 1, 1'b1);
      offer_cell(REQ_QUERY, 3, 1, 1'b0);
      offer_cell(REQ_QUERY, 2, 0, 1'b0);
      set_grid(0, 5);
      offer_cell(REQ_WRITE, 0, 0, 1'b1);
      offer_cell(REQ_QUERY, 0, 0, 1'b0);

      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         if (seg == 3) begin
            req_idle_pct = 52;
            rsp_idle_pct <= 38;
         end
         if (seg == 6) begin
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         set_grid(SEG_COLS[seg], SEG_ROWS[seg]);
         // hold the result side off while requests keep coming
         if (seg == 7) holdoff_armed <= 1'b1;
         cols_used = (SEG_COLS[seg] > 64) ? 64 : SEG_COLS[seg];
         rows_used = (SEG_ROWS[seg] > 64) ? 64 : SEG_ROWS[seg];
         focus_x = 0;
         focus_y = 0;
         for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
            if (k % 16 == 0) begin
               focus_x = (cols_used > 0) ? int'($urandom_range(cols_used - 1)) : 0;
               focus_y = (rows_used > 0) ? int'($urandom_range(rows_used - 1)) : 0;
            end
            offer_cell($urandom_range(1) ? REQ_QUERY : REQ_WRITE,
                       pick_axis(focus_x, SEG_COLS[seg]),
                       pick_axis(focus_y, SEG_ROWS[seg]),
                       $urandom_range(99) < 65);
         end
      end

      req_valid <= 1'b0;
      while (beats_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && beats_due == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/gng_pkg.sv
src/gng_ram.sv
src/gng_front.sv
src/gng_back.sv
src/grid_neighbor_generator_unit.sv
dv/gng_neighbor_checker.sv
dv/tb_grid_neighbor_generator_unit.sv
